// File: rtl/core/ugas_pkg.sv
// Shared types for the undirected graph adjacency store.
// Holds operation and status codes and the item structs that cross module
// boundaries. No dependencies.
`default_nettype none

package ugas_pkg;

  // Operation codes, encoded as the input mode field.
  typedef enum logic [1:0] {
    OP_INS_V = 2'd0,
    OP_DEL_V = 2'd1,
    OP_INS_E = 2'd2,
    OP_DEL_E = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NO_EDGE   = 3'd4
  } status_t;

  // Back end sequencer states.
  typedef enum logic {
    BK_LOOK = 1'b0,
    BK_EXEC = 1'b1
  } bk_state_t;

  // Width of the vertex count result field.
  localparam int COUNT_W = 5;
  localparam int LABEL_W = 8;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    op_t                op;
    logic               is_edge;
    logic [LABEL_W-1:0] label_a;
    logic [LABEL_W-1:0] label_b;
  } cmd_t;

  // Result item.
  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] vertex_count;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/ugas_fifo.sv
// Two-entry register queue used between pipeline parts.
// Generic payload width; no package dependencies.
`default_nettype none

module ugas_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wptr_r;
  logic             rptr_r;
  logic [1:0]       cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_r <= ~wptr_r;
      end
      if (do_pop) begin
        rptr_r <= ~rptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ugas_front.sv
// Front end: accepts input items, classifies the operation and queues it.
// Depends on ugas_pkg and ugas_fifo.
`default_nettype none

module ugas_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [ugas_pkg::LABEL_W-1:0]  in_label_a,
  input  wire logic [ugas_pkg::LABEL_W-1:0]  in_label_b,
  input  wire logic                          cmd_pop,
  output logic                               cmd_empty,
  output ugas_pkg::cmd_t                     cmd
);

  ugas_pkg::cmd_t                    cmd_in;
  logic [$bits(ugas_pkg::cmd_t)-1:0] cmd_vec;

  // Classify the item: decode the operation and mark edge operations,
  // which need both endpoints looked up.
  always_comb begin
    cmd_in.op      = ugas_pkg::op_t'(in_mode);
    cmd_in.label_a = in_label_a;
    cmd_in.label_b = in_label_b;
    case (cmd_in.op)
      ugas_pkg::OP_INS_E, ugas_pkg::OP_DEL_E: cmd_in.is_edge = 1'b1;
      default:                                cmd_in.is_edge = 1'b0;
    endcase
  end

  ugas_fifo #(
    .WIDTH($bits(ugas_pkg::cmd_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd_vec),
    .empty (cmd_empty)
  );

  assign cmd = ugas_pkg::cmd_t'(cmd_vec);

endmodule

`default_nettype wire

// File: rtl/core/ugas_back.sv
// Back end: holds the label list and adjacency matrix and executes commands
// in a look-up state followed by an execute state. Depends on ugas_pkg.
`default_nettype none

module ugas_back #(
  parameter int N = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_empty,
  input  ugas_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  wire logic           res_full,
  output logic                res_push,
  output ugas_pkg::res_t      res
);

  localparam int CW = $clog2(N + 1);
  localparam int LW = ugas_pkg::LABEL_W;

  // Graph storage, one register row per vertex entry.
  logic [LW-1:0] label_r  [N];
  logic [N-1:0]  row_r    [N];
  logic [CW-1:0] count_r;

  // Sequencer and look-up results.
  ugas_pkg::bk_state_t state_r, state_nxt;
  ugas_pkg::op_t       op_r;
  logic [LW-1:0]       a_r;
  logic [N-1:0]        hit_a_r, hit_b_r;
  ugas_pkg::status_t   status_r;

  logic [N-1:0]        vld, hit_a, hit_b, sel_n, below, ge;
  logic                found_a, found_b, full, edge_on;
  ugas_pkg::status_t   status_nxt;
  logic                commit;
  logic [N-1:0]        srow     [N];
  logic [LW-1:0]       label_nxt[N];
  logic [N-1:0]        row_nxt  [N];
  logic [CW-1:0]       count_nxt;
  logic [CW-1:0]       count_out;
  logic [CW+ugas_pkg::COUNT_W-1:0] count_ext;

  // Parallel label search against the live entries.
  always_comb begin
    edge_on = 1'b0;
    for (int j = 0; j < N; j++) begin
      vld[j]   = (CW'(j) < count_r);
      hit_a[j] = vld[j] && (label_r[j] == cmd.label_a);
      hit_b[j] = vld[j] && (label_r[j] == cmd.label_b);
      edge_on  = edge_on | (hit_a[j] & (|(row_r[j] & hit_b)));
    end
    found_a = |hit_a;
    found_b = |hit_b;
    full    = (count_r == CW'(N));
  end

  // Status of the command at the queue head.
  always_comb begin
    status_nxt = ugas_pkg::ST_OK;
    if (cmd.is_edge) begin
      if (!(found_a && found_b)) begin
        status_nxt = ugas_pkg::ST_NOT_FOUND;
      end else if (cmd.op == ugas_pkg::OP_DEL_E && !edge_on) begin
        status_nxt = ugas_pkg::ST_NO_EDGE;
      end
    end else begin
      case (cmd.op)
        ugas_pkg::OP_INS_V: begin
          if (full) begin
            status_nxt = ugas_pkg::ST_FULL;
          end else if (found_a) begin
            status_nxt = ugas_pkg::ST_EXISTS;
          end
        end
        ugas_pkg::OP_DEL_V: begin
          if (!found_a) begin
            status_nxt = ugas_pkg::ST_NOT_FOUND;
          end
        end
        default: status_nxt = ugas_pkg::ST_OK;
      endcase
    end
  end

  // Sequencer: look up the head command, then execute and post the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ugas_pkg::BK_LOOK;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    case (state_r)
      ugas_pkg::BK_LOOK: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          state_nxt = ugas_pkg::BK_EXEC;
        end
      end
      ugas_pkg::BK_EXEC: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ugas_pkg::BK_LOOK;
        end
      end
      default: state_nxt = ugas_pkg::BK_LOOK;
    endcase
  end

  // Look-up results held for the execute state.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      op_r     <= cmd.op;
      a_r      <= cmd.label_a;
      hit_a_r  <= hit_a;
      hit_b_r  <= hit_b;
      status_r <= status_nxt;
    end
  end

  assign commit = res_push && (status_r == ugas_pkg::ST_OK);

  // Position masks: the slot being appended, and the bits below and at or
  // above a deleted entry (the hit vector is one-hot).
  always_comb begin
    for (int j = 0; j < N; j++) begin
      sel_n[j] = (CW'(j) == count_r);
    end
    below = hit_a_r - N'(1);
    ge    = ~below;
  end

  // Compaction source rows for vertex delete: later entries move down.
  always_comb begin
    for (int j = 0; j < N - 1; j++) begin
      srow[j] = ge[j] ? row_r[j + 1] : row_r[j];
    end
    srow[N-1] = row_r[N-1];
  end

  // Next contents of the graph storage.
  always_comb begin
    count_nxt = count_r;
    for (int j = 0; j < N; j++) begin
      label_nxt[j] = label_r[j];
      row_nxt[j]   = row_r[j];
    end
    case (op_r)
      ugas_pkg::OP_INS_V: begin
        count_nxt = count_r + CW'(1);
        for (int j = 0; j < N; j++) begin
          label_nxt[j] = sel_n[j] ? a_r : label_r[j];
          row_nxt[j]   = sel_n[j] ? '0 : (row_r[j] & ~sel_n);
        end
      end
      ugas_pkg::OP_DEL_V: begin
        count_nxt = count_r - CW'(1);
        for (int j = 0; j < N - 1; j++) begin
          label_nxt[j] = ge[j] ? label_r[j + 1] : label_r[j];
        end
        for (int j = 0; j < N; j++) begin
          row_nxt[j] = (srow[j] & below) | ((srow[j] >> 1) & ge);
        end
      end
      ugas_pkg::OP_INS_E: begin
        for (int j = 0; j < N; j++) begin
          row_nxt[j] = row_r[j] | (hit_a_r[j] ? hit_b_r : '0)
                                | (hit_b_r[j] ? hit_a_r : '0);
        end
      end
      ugas_pkg::OP_DEL_E: begin
        for (int j = 0; j < N; j++) begin
          row_nxt[j] = row_r[j] & ~(hit_a_r[j] ? hit_b_r : '0)
                                & ~(hit_b_r[j] ? hit_a_r : '0);
        end
      end
      default: count_nxt = count_r;
    endcase
  end

  // Storage update on a successful command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (commit) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      for (int j = 0; j < N; j++) begin
        label_r[j] <= label_nxt[j];
        row_r[j]   <= row_nxt[j];
      end
    end
  end

  // Result: status and the count after this command, masked to five bits.
  assign count_out        = commit ? count_nxt : count_r;
  assign count_ext        = {{ugas_pkg::COUNT_W{1'b0}}, count_out};
  assign res.status       = status_r;
  assign res.vertex_count = count_ext[ugas_pkg::COUNT_W-1:0];

endmodule

`default_nettype wire

// File: rtl/core/undirected_graph_adjacency_store.sv
// Undirected graph adjacency store: label list plus symmetric bit matrix.
// A result passes the command queue, the back end look-up and execute states
// and the result queue. The back end takes a new command only after posting
// the last result, as its look-up and execute states share the graph registers.
// Reset clears the vertex count and empties both queues; label and matrix
// storage is not cleared and needs no clearing pass.
`default_nettype none

module undirected_graph_adjacency_store #(
  parameter int MAX_VERTICES = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_push,
  output logic                              in_full,
  input  wire logic [1:0]                   in_mode,
  input  wire logic [ugas_pkg::LABEL_W-1:0] in_label_a,
  input  wire logic [ugas_pkg::LABEL_W-1:0] in_label_b,
  output logic                              out_empty,
  input  wire logic                         out_pop,
  output logic [2:0]                        out_status,
  output logic [ugas_pkg::COUNT_W-1:0]      out_vertex_count
);

  ugas_pkg::cmd_t                    cmd;
  logic                              cmd_empty;
  logic                              cmd_pop;
  logic                              res_full;
  logic                              res_push;
  ugas_pkg::res_t                    res;
  logic [$bits(ugas_pkg::res_t)-1:0] res_vec;
  ugas_pkg::res_t                    res_out;

  // Front end: accept and classify items.
  ugas_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_mode    (in_mode),
    .in_label_a (in_label_a),
    .in_label_b (in_label_b),
    .cmd_pop    (cmd_pop),
    .cmd_empty  (cmd_empty),
    .cmd        (cmd)
  );

  // Back end: graph storage and command execution.
  ugas_back #(
    .N(MAX_VERTICES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Result queue toward the consumer.
  ugas_fifo #(
    .WIDTH($bits(ugas_pkg::res_t))
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_vec),
    .empty (out_empty)
  );

  assign res_out          = ugas_pkg::res_t'(res_vec);
  assign out_status       = res_out.status;
  assign out_vertex_count = res_out.vertex_count;

  // The back end only posts into a result queue with room.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result posted into a full queue");

  // Each command passes the look-up and then the execute state before the next is taken.
  a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> !cmd_pop)
    else $error("commands taken on back-to-back cycles");

  // A command is taken only from a non-empty queue.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command taken from an empty queue");

  // A full store reports the maximum count.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.status == ugas_pkg::ST_FULL) |->
      (res.vertex_count == ugas_pkg::COUNT_W'(MAX_VERTICES)))
    else $error("store full reported with a short count");

endmodule

`default_nettype wire

// File: tb/tb_undirected_graph_adjacency_store.sv
// Testbench for the undirected graph adjacency store: queue-style drivers on
// both sides and a scoreboard that predicts status and vertex count per item.
// Depends on ugas_pkg and the undirected_graph_adjacency_store RTL.
`default_nettype none

module tb_undirected_graph_adjacency_store;

  localparam int N_VERT      = 16;
  localparam int RANDOM_GOAL = 1200;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int POOL_N      = 24;
  localparam int DRAIN_WAIT  = 8;

  // Kinds of random phases; each one tilts the operation mix.
  typedef enum {PH_FILL, PH_GROW, PH_SHRINK, PH_MIX} phase_kind_t;

  typedef struct {
    ugas_pkg::op_t op;
    logic [7:0]    a;
    logic [7:0]    b;
  } graph_cmd_t;

  // Scoreboard: mirrors the label list and adjacency matrix and queues the
  // expected result of every accepted item.
  class graph_scoreboard #(int NV = 16);
    localparam int NO_SLOT = -1;

    logic [7:0]     labels [NV];
    logic [NV-1:0]  adj [NV];
    int             nverts;
    ugas_pkg::res_t expected_q [$];
    int             errors;
    int             results_seen;
    int             items_seen;
    int             status_hits [5];
    int             peak;

    function new();
      for (int j = 0; j < NV; j++) begin
        labels[j] = '0;
        adj[j]    = '0;
      end
      nverts       = 0;
      errors       = 0;
      results_seen = 0;
      items_seen   = 0;
      peak         = 0;
      for (int j = 0; j < 5; j++) status_hits[j] = 0;
    endfunction

    function int slot_of(logic [7:0] lab);
      for (int j = 0; j < nverts; j++) begin
        if (labels[j] == lab) return j;
      end
      return NO_SLOT;
    endfunction

    // A random neighbor slot of slot p, used to aim edge deletes at real edges.
    function int some_neighbor(int p);
      int start;
      int k;
      start = $urandom_range(0, nverts - 1);
      for (int i = 0; i < nverts; i++) begin
        k = (start + i) % nverts;
        if (adj[p][k]) return k;
      end
      return NO_SLOT;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Apply one accepted item to the mirrored graph and queue its result.
    function void note_item(ugas_pkg::op_t op, logic [7:0] a, logic [7:0] b);
      int                pa;
      int                pb;
      ugas_pkg::status_t st;
      logic [NV-1:0]     keep;
      st = ugas_pkg::ST_OK;
      items_seen++;
      case (op)
        ugas_pkg::OP_INS_V: begin
          if (nverts >= NV) st = ugas_pkg::ST_FULL;
          else if (slot_of(a) != NO_SLOT) st = ugas_pkg::ST_EXISTS;
          else begin
            for (int j = 0; j < nverts; j++) adj[j][nverts] = 1'b0;
            adj[nverts]    = '0;
            labels[nverts] = a;
            nverts++;
          end
        end
        ugas_pkg::OP_DEL_V: begin
          pa = slot_of(a);
          if (pa == NO_SLOT) st = ugas_pkg::ST_NOT_FOUND;
          else begin
            // Later entries move down one slot, then the column is squeezed out.
            for (int j = pa; j + 1 < nverts; j++) begin
              adj[j]    = adj[j + 1];
              labels[j] = labels[j + 1];
            end
            keep = {NV{1'b1}} >> (NV - pa);
            for (int j = 0; j + 1 < nverts; j++) begin
              adj[j] = (adj[j] & keep) | ((adj[j] >> (pa + 1)) << pa);
            end
            nverts--;
          end
        end
        default: begin
          pa = slot_of(a);
          pb = slot_of(b);
          if (pa == NO_SLOT || pb == NO_SLOT) st = ugas_pkg::ST_NOT_FOUND;
          else if (op == ugas_pkg::OP_INS_E) begin
            adj[pa][pb] = 1'b1;
            adj[pb][pa] = 1'b1;
          end else if (!adj[pa][pb]) st = ugas_pkg::ST_NO_EDGE;
          else begin
            adj[pa][pb] = 1'b0;
            adj[pb][pa] = 1'b0;
          end
        end
      endcase
      status_hits[st]++;
      if (nverts > peak) peak = nverts;
      expected_q.push_back('{status: st, vertex_count: ugas_pkg::COUNT_W'(nverts)});
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] exp_val);
      errors++;
      if (errors <= 40) begin
        $display("[%0t] result %0d: %s got %0d, want %0d",
                 $time, results_seen, what, got, exp_val);
      end
    endtask

    // Compare one popped result with the oldest expectation.
    task check_result(logic [2:0] st, logic [ugas_pkg::COUNT_W-1:0] cnt);
      ugas_pkg::res_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("unexpected result, status", 8'(st), 8'd0);
        return;
      end
      want = expected_q.pop_front();
      if (st !== want.status) report("status", 8'(st), 8'(want.status));
      if (cnt !== want.vertex_count) begin
        report("vertex count", 8'(cnt), 8'(want.vertex_count));
      end
    endtask
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_push;
  logic                         in_full;
  logic [1:0]                   in_mode;
  logic [7:0]                   in_label_a;
  logic [7:0]                   in_label_b;
  logic                         out_empty;
  logic                         out_pop;
  logic [2:0]                   out_status;
  logic [ugas_pkg::COUNT_W-1:0] out_vertex_count;

  graph_scoreboard #(N_VERT) sb;
  logic [7:0]                label_pool [POOL_N];
  bit                        calm;
  int                        rx_wait;
  int                        rx_gap;
  int                        cycles;

  undirected_graph_adjacency_store #(.MAX_VERTICES(N_VERT)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_mode          (in_mode),
    .in_label_a       (in_label_a),
    .in_label_b       (in_label_b),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_vertex_count (out_vertex_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long; zero in calm phases.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic ugas_pkg::op_t pick_op(phase_kind_t kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      PH_FILL: return ugas_pkg::OP_INS_V;
      PH_GROW: begin
        if (r < 35) return ugas_pkg::OP_INS_V;
        if (r < 40) return ugas_pkg::OP_DEL_V;
        if (r < 75) return ugas_pkg::OP_INS_E;
        return ugas_pkg::OP_DEL_E;
      end
      PH_SHRINK: begin
        if (r < 5) return ugas_pkg::OP_INS_V;
        if (r < 40) return ugas_pkg::OP_DEL_V;
        if (r < 75) return ugas_pkg::OP_INS_E;
        return ugas_pkg::OP_DEL_E;
      end
      default: begin
        if (r < 20) return ugas_pkg::OP_INS_V;
        if (r < 40) return ugas_pkg::OP_DEL_V;
        if (r < 70) return ugas_pkg::OP_INS_E;
        return ugas_pkg::OP_DEL_E;
      end
    endcase
  endfunction

  // Labels lean toward stored ones so that edge and delete items find targets.
  function automatic logic [7:0] pick_label();
    int r;
    r = $urandom_range(0, 99);
    if (sb.nverts > 0 && r < 70) return sb.labels[$urandom_range(0, sb.nverts - 1)];
    if (r < 85) return label_pool[$urandom_range(0, POOL_N - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_item(ugas_pkg::op_t op, logic [7:0] a, logic [7:0] b);
    in_push    <= 1'b1;
    in_mode    <= op;
    in_label_a <= a;
    in_label_b <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_item(op, a, b);
  endtask

  // Optional gap after an item; the label fields carry junk while push is low.
  task automatic idle_sender();
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_push    <= 1'b0;
      in_label_a <= 8'($urandom_range(0, 255));
      in_label_b <= 8'($urandom_range(0, 255));
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: pop with random stalls and check each accepted result.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      rx_wait <= 0;
    end else if (out_pop && !out_empty) begin
      sb.check_result(out_status, out_vertex_count);
      rx_gap = pick_gap();
      if (rx_gap > 0) begin
        out_pop <= 1'b0;
        rx_wait <= rx_gap;
      end
    end else if (!out_pop) begin
      if (rx_wait <= 1) out_pop <= 1'b1;
      if (rx_wait > 0) rx_wait <= rx_wait - 1;
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped at the cycle limit with %0d results outstanding.", sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    graph_cmd_t    directed [21];
    phase_kind_t   kind;
    ugas_pkg::op_t op;
    logic [7:0]    a;
    logic [7:0]    b;
    int            random_sent;
    int            phase_len;
    int            phase_no;
    int            pa;
    int            pb;

    sb         = new();
    calm       = 1'b0;
    rst_n      <= 1'b0;
    in_push    <= 1'b0;
    in_mode    <= ugas_pkg::OP_INS_V;
    in_label_a <= '0;
    in_label_b <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Empty-store lookups, duplicates, self loops, missing edges, and deletes
    // from the middle, the front and the back of the list.
    directed = '{
      '{ugas_pkg::OP_DEL_V, 8'h00, 8'h00}, '{ugas_pkg::OP_INS_E, 8'h00, 8'h00},
      '{ugas_pkg::OP_DEL_E, 8'hFF, 8'hFF}, '{ugas_pkg::OP_INS_V, 8'h00, 8'hFF},
      '{ugas_pkg::OP_INS_V, 8'hFF, 8'h00}, '{ugas_pkg::OP_INS_V, 8'hFF, 8'hFF},
      '{ugas_pkg::OP_INS_E, 8'h00, 8'h00}, '{ugas_pkg::OP_DEL_E, 8'h00, 8'h00},
      '{ugas_pkg::OP_DEL_E, 8'h00, 8'h00}, '{ugas_pkg::OP_INS_E, 8'h00, 8'hFF},
      '{ugas_pkg::OP_INS_E, 8'h00, 8'h5A}, '{ugas_pkg::OP_DEL_E, 8'hA5, 8'h00},
      '{ugas_pkg::OP_INS_V, 8'h5A, 8'h00}, '{ugas_pkg::OP_INS_E, 8'h5A, 8'hFF},
      '{ugas_pkg::OP_INS_E, 8'h5A, 8'h5A}, '{ugas_pkg::OP_DEL_V, 8'hFF, 8'h00},
      '{ugas_pkg::OP_DEL_E, 8'h00, 8'h5A}, '{ugas_pkg::OP_DEL_V, 8'h00, 8'hFF},
      '{ugas_pkg::OP_DEL_E, 8'h5A, 8'h5A}, '{ugas_pkg::OP_DEL_V, 8'h5A, 8'h00},
      '{ugas_pkg::OP_DEL_V, 8'h5A, 8'hFF}
    };
    foreach (directed[i]) begin
      send_item(directed[i].op, directed[i].a, directed[i].b);
      idle_sender();
    end

    // Random phases; the first one fills the store and runs into the full case.
    kind        = PH_FILL;
    random_sent = 0;
    phase_no    = 0;
    while (random_sent < RANDOM_GOAL) begin
      foreach (label_pool[i]) label_pool[i] = 8'($urandom_range(0, 255));
      calm      = ($urandom_range(0, 4) == 0);
      phase_len = (kind == PH_FILL) ? 24 : $urandom_range(30, 120);
      for (int n = 0; n < phase_len && random_sent < RANDOM_GOAL; n++) begin
        op = pick_op(kind);
        b  = pick_label();
        if (kind == PH_FILL && $urandom_range(0, 99) < 85) a = 8'($urandom_range(0, 255));
        else a = pick_label();
        if (op == ugas_pkg::OP_DEL_E && sb.nverts > 0 && $urandom_range(0, 1) == 1) begin
          pa = $urandom_range(0, sb.nverts - 1);
          pb = sb.some_neighbor(pa);
          if (pb >= 0) begin
            a = sb.labels[pa];
            b = sb.labels[pb];
          end
        end
        send_item(op, a, b);
        random_sent++;
        idle_sender();
      end
      // Let the block run dry now and then before the next phase.
      if (phase_no == 0 || $urandom_range(0, 3) == 0) wait_all_results();
      phase_no++;
      kind = phase_kind_t'($urandom_range(0, 3));
    end

    wait_all_results();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d items in %0d phases, peak of %0d vertices stored.",
             sb.items_seen, phase_no, sb.peak);
    $display("Status mix: ok %0d, full %0d, exists %0d, not found %0d, no edge %0d.",
             sb.status_hits[ugas_pkg::ST_OK], sb.status_hits[ugas_pkg::ST_FULL],
             sb.status_hits[ugas_pkg::ST_EXISTS], sb.status_hits[ugas_pkg::ST_NOT_FOUND],
             sb.status_hits[ugas_pkg::ST_NO_EDGE]);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
